// File: sv/swd_pkg.sv
// Shared types and constants for the sync word deframer.
// Used by swd_front, swd_queue and sync_word_deframer; depends on nothing.
package swd_pkg;

    localparam int SYNC_PATTERN_W  = 16;
    localparam int SEARCH_WINDOW_W = 8;
    localparam int PAYLOAD_BYTES_W = 6;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_ADDR_W      = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_PATTERN  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SEARCH_WINDOW = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PAYLOAD_BYTES = 2'd2;

    localparam logic [SYNC_PATTERN_W-1:0]  SYNC_PATTERN_RST  = 16'hD391;
    localparam logic [SEARCH_WINDOW_W-1:0] SEARCH_WINDOW_RST = 8'd100;
    localparam logic [PAYLOAD_BYTES_W-1:0] PAYLOAD_BYTES_RST = 6'd9;

    // A zero payload length stands for the full 64 bytes.
    localparam logic [PAYLOAD_BYTES_W:0] FRAME_LEN_MAX = 7'd64;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic [SYNC_PATTERN_W-1:0]  sync_pattern;
        logic [SEARCH_WINDOW_W-1:0] search_window;
        logic [PAYLOAD_BYTES_W-1:0] payload_bytes;
    } cfg_t;

endpackage

// File: sv/swd_front.sv
// Deframer front end: sync search and byte packing, one bit per bit_valid cycle.
// Depends on swd_pkg; hands completed bytes to the result queue.
module swd_front #(
    parameter int SYNC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           bit_valid,
    input  logic           rx_bit,
    input  swd_pkg::cfg_t  cfg,
    output logic           beat_valid,
    output swd_pkg::beat_t beat
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SEARCH,
        MODE_COLLECT
    } mode_t;

    mode_t                                mode_reg, mode_next;
    logic [swd_pkg::SEARCH_WINDOW_W-1:0]  win_reg, win_next;
    logic [SYNC_BITS-1:0]                 shift_reg, shift_next;
    logic [7:0]                           acc_reg, acc_next;
    logic [2:0]                           bit_in_reg, bit_in_next;
    logic [swd_pkg::PAYLOAD_BYTES_W-1:0]  bytes_reg, bytes_next;

    logic [SYNC_BITS-1:0]                 sync_cmp;
    logic [swd_pkg::SEARCH_WINDOW_W-1:0]  win_inc;
    logic [SYNC_BITS-1:0]                 shift_in;
    logic [7:0]                           acc_in;
    logic [swd_pkg::PAYLOAD_BYTES_W:0]    frame_len;
    logic [swd_pkg::PAYLOAD_BYTES_W:0]    bytes_plus;
    logic                                 is_last;

    // Pattern bits above the sixteenth are zero; a shorter sync uses the low bits.
    generate
        if (SYNC_BITS >= swd_pkg::SYNC_PATTERN_W) begin : g_wide
            assign sync_cmp = SYNC_BITS'(cfg.sync_pattern);
        end
        else begin : g_narrow
            assign sync_cmp = cfg.sync_pattern[SYNC_BITS-1:0];
        end
    endgenerate

    assign win_inc    = (win_reg == '1) ? win_reg : win_reg + 1'b1;
    assign shift_in   = {shift_reg[SYNC_BITS-2:0], rx_bit};
    assign acc_in     = {acc_reg[6:0], rx_bit};
    assign frame_len  = (cfg.payload_bytes == '0) ? swd_pkg::FRAME_LEN_MAX
                                                  : {1'b0, cfg.payload_bytes};
    assign bytes_plus = {1'b0, bytes_reg} + 1'b1;
    assign is_last    = (bytes_plus >= frame_len);

    always_comb
    begin
        mode_next   = mode_reg;
        win_next    = win_reg;
        shift_next  = shift_reg;
        acc_next    = acc_reg;
        bit_in_next = bit_in_reg;
        bytes_next  = bytes_reg;
        beat_valid  = 1'b0;
        beat.data   = acc_in;
        beat.last   = is_last;
        if (bit_valid)
        begin
            unique case (mode_reg)
                MODE_SEARCH:
                begin
                    if (win_reg == cfg.search_window)
                    begin
                        // Window used up: this bit is dropped.
                        mode_next  = MODE_IDLE;
                        win_next   = '0;
                        shift_next = '0;
                    end
                    else
                    begin
                        shift_next = shift_in;
                        win_next   = win_inc;
                        if ((win_inc >= swd_pkg::SEARCH_WINDOW_W'(SYNC_BITS)) &&
                            (shift_in == sync_cmp))
                        begin
                            mode_next   = MODE_COLLECT;
                            win_next    = '0;
                            shift_next  = '0;
                            acc_next    = '0;
                            bit_in_next = '0;
                            bytes_next  = '0;
                        end
                    end
                end
                MODE_COLLECT:
                begin
                    if (bit_in_reg != 3'd7)
                    begin
                        acc_next    = acc_in;
                        bit_in_next = bit_in_reg + 1'b1;
                    end
                    else
                    begin
                        beat_valid  = 1'b1;
                        acc_next    = '0;
                        bit_in_next = '0;
                        if (is_last)
                        begin
                            mode_next  = MODE_IDLE;
                            bytes_next = '0;
                        end
                        else
                        begin
                            bytes_next = bytes_plus[swd_pkg::PAYLOAD_BYTES_W-1:0];
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    if (!rx_bit)
                    begin
                        // The opening zero counts as the first searched bit.
                        shift_next = '0;
                        win_next   = '0;
                        if (cfg.search_window != '0)
                        begin
                            mode_next = MODE_SEARCH;
                            win_next  = swd_pkg::SEARCH_WINDOW_W'(1);
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            win_reg    <= '0;
            shift_reg  <= '0;
            acc_reg    <= '0;
            bit_in_reg <= '0;
            bytes_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            win_reg    <= win_next;
            shift_reg  <= shift_next;
            acc_reg    <= acc_next;
            bit_in_reg <= bit_in_next;
            bytes_reg  <= bytes_next;
        end
    end

endmodule

// File: sv/swd_queue.sv
// Small result queue between the deframer front end and the result port.
// Depends on swd_pkg for the beat type.
module swd_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  swd_pkg::beat_t push_beat,
    input  logic           pop,
    output swd_pkg::beat_t head,
    output logic           empty,
    output logic           full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    swd_pkg::beat_t   entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/sync_word_deframer.sv
// Sync word deframer: takes one received bit a cycle, when push is high and full low.
// Each byte is queued the cycle after its final bit is taken and read out in order.
// full rises only when QUEUE_DEPTH bytes wait unread; push and full pace the bits.
// Reset empties the queue, returns to idle and loads the register reset values.
// Top level; depends on swd_pkg, swd_front and swd_queue.
module sync_word_deframer #(
    parameter int SYNC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            rx_bit,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      data_byte,
    output logic                            last_byte,
    input  logic                            cfg_we,
    input  logic [swd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [swd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    swd_pkg::cfg_t  cfg_reg;
    swd_pkg::beat_t front_beat;
    swd_pkg::beat_t head_beat;
    logic           front_valid;
    logic           bit_accept;

    assign bit_accept = push && !full;

    // Register writes take effect at once; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_pattern  <= swd_pkg::SYNC_PATTERN_RST;
            cfg_reg.search_window <= swd_pkg::SEARCH_WINDOW_RST;
            cfg_reg.payload_bytes <= swd_pkg::PAYLOAD_BYTES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                swd_pkg::REG_SYNC_PATTERN:
                    cfg_reg.sync_pattern <= cfg_wdata;
                swd_pkg::REG_SEARCH_WINDOW:
                    cfg_reg.search_window <= cfg_wdata[swd_pkg::SEARCH_WINDOW_W-1:0];
                swd_pkg::REG_PAYLOAD_BYTES:
                    cfg_reg.payload_bytes <= cfg_wdata[swd_pkg::PAYLOAD_BYTES_W-1:0];
                default:
                    ;
            endcase
        end
    end

    swd_front #(
        .SYNC_BITS (SYNC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bit_valid  (bit_accept),
        .rx_bit     (rx_bit),
        .cfg        (cfg_reg),
        .beat_valid (front_valid),
        .beat       (front_beat)
    );

    // full is the queue's own full flag, so a byte from an accepted bit always fits.
    swd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_beat (front_beat),
        .pop       (pop),
        .head      (head_beat),
        .empty     (empty),
        .full      (full)
    );

    assign data_byte = head_beat.data;
    assign last_byte = head_beat.last;

endmodule
